// ----- sv/dfw_pkg.sv -----
package dfw_pkg;

   // Graph sizing
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_DEGREE   = 16;
   localparam int VX_W         = $clog2(MAX_VERTICES);
   localparam int SLOT_W       = $clog2(MAX_DEGREE);
   localparam int DEG_W        = SLOT_W + 1;
   localparam int CNT_W        = VX_W + 1;
   localparam int NB_AW        = VX_W + SLOT_W;
   localparam int FUNC_W       = 2;
   localparam int EV_W         = 3;

   // Item function codes
   localparam logic [FUNC_W-1:0] FUNC_WR_DEG = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WR_NB  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd3;

   // Event codes
   localparam logic [EV_W-1:0] EV_DISCOVER = 3'd0;
   localparam logic [EV_W-1:0] EV_PRE_EDGE = 3'd1;
   localparam logic [EV_W-1:0] EV_POST_EDGE = 3'd2;
   localparam logic [EV_W-1:0] EV_FINISH   = 3'd3;
   localparam logic [EV_W-1:0] EV_DONE     = 3'd4;

   // Vertex colours
   localparam logic [1:0] COL_WHITE = 2'd0;
   localparam logic [1:0] COL_GRAY  = 2'd1;
   localparam logic [1:0] COL_BLACK = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VX_W-1:0]   vertex;
      logic [SLOT_W-1:0] slot;
      logic [DEG_W-1:0]  degree;
      logic [VX_W-1:0]   neighbor;
   } cmd_type;

   typedef struct packed {
      logic [VX_W-1:0]  v;
      logic [DEG_W-1:0] k;
   } frame_type;

endpackage

// ----- sv/dfw_req_if.sv -----
interface dfw_req_if;
   logic                             valid;
   logic                             ready;
   logic [dfw_pkg::FUNC_W-1:0]       func;
   logic [dfw_pkg::VX_W-1:0]         vertex;
   logic [dfw_pkg::SLOT_W-1:0]       slot;
   logic [dfw_pkg::DEG_W-1:0]        degree;
   logic [dfw_pkg::VX_W-1:0]         neighbor;

   modport source (output valid, func, vertex, slot, degree, neighbor, input ready);
   modport sink (input valid, func, vertex, slot, degree, neighbor, output ready);
endinterface

// ----- sv/dfw_rsp_if.sv -----
interface dfw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dfw_pkg::EV_W-1:0]    event_res;
   logic [dfw_pkg::VX_W-1:0]    node;
   logic [dfw_pkg::SLOT_W-1:0]  edge_slot;
   logic                        last;

   modport source (output valid, event_res, node, edge_slot, last, input ready);
   modport sink (input valid, event_res, node, edge_slot, last, output ready);
endinterface

// ----- sv/dfw_front.sv -----
module dfw_front (
   input  logic             clock,
   input  logic             reset,
   dfw_req_if.sink          req_ch,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output dfw_pkg::cmd_type cmd
);

   dfw_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;
   dfw_pkg::cmd_type item;

   // Pass the incoming item through and clip its degree
   always_comb begin
      item.func     = req_ch.func;
      item.vertex   = req_ch.vertex;
      item.slot     = req_ch.slot;
      item.neighbor = req_ch.neighbor;
      if (req_ch.degree > dfw_pkg::DEG_W'(dfw_pkg::MAX_DEGREE)) begin
         item.degree = dfw_pkg::DEG_W'(dfw_pkg::MAX_DEGREE);
      end else begin
         item.degree = req_ch.degree;
      end
   end

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (cnt_ff != 2'd0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = q_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- sv/dfw_back.sv -----
module dfw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  dfw_pkg::cmd_type           cmd,
   input  logic                       csr_wr_en,
   input  logic [dfw_pkg::CNT_W-1:0]  csr_wr_data,
   dfw_rsp_if.source                  rsp_ch
);

   typedef enum logic [12:0] {
      ST_CLEAR    = 13'b0000000000001,
      ST_IDLE     = 13'b0000000000010,
      ST_SCAN_RD  = 13'b0000000000100,
      ST_SCAN_CHK = 13'b0000000001000,
      ST_POP      = 13'b0000000010000,
      ST_U_LD     = 13'b0000000100000,
      ST_U_RD     = 13'b0000001000000,
      ST_U_CHK    = 13'b0000010000000,
      ST_BRANCH   = 13'b0000100000000,
      ST_NB       = 13'b0001000000000,
      ST_VCHK     = 13'b0010000000000,
      ST_POST     = 13'b0100000000000,
      ST_PARENT   = 13'b1000000000000
   } state_type;

   localparam int VX_W   = dfw_pkg::VX_W;
   localparam int CNT_W  = dfw_pkg::CNT_W;
   localparam int DEG_W  = dfw_pkg::DEG_W;
   localparam int SLOT_W = dfw_pkg::SLOT_W;

   // Memories
   logic [DEG_W-1:0]    deg_mem [dfw_pkg::MAX_VERTICES];
   logic [VX_W-1:0]     nb_mem  [dfw_pkg::MAX_VERTICES * dfw_pkg::MAX_DEGREE];
   logic [1:0]          col_mem [dfw_pkg::MAX_VERTICES];
   dfw_pkg::frame_type  stk_mem [dfw_pkg::MAX_VERTICES];

   logic [DEG_W-1:0]   deg_q;
   logic [VX_W-1:0]    nb_q;
   logic [1:0]         col_q;
   dfw_pkg::frame_type stk_q;

   logic                     deg_we, deg_re;
   logic [VX_W-1:0]          deg_wa, deg_ra;
   logic                     nb_we, nb_re;
   logic [dfw_pkg::NB_AW-1:0] nb_wa, nb_ra;
   logic                     col_we, col_re;
   logic [VX_W-1:0]          col_wa, col_ra;
   logic [1:0]               col_wd;
   logic                     stk_we, stk_re;
   logic [VX_W-1:0]          stk_wa, stk_ra;
   dfw_pkg::frame_type       stk_wd;

   // Control registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [VX_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] vc_ff;
   logic             out_valid_ff, out_valid_in;

   // Payload registers
   logic [VX_W-1:0]         u_ff, u_in;
   logic [DEG_W-1:0]        k_ff, k_in;
   logic [VX_W-1:0]         v_ff, v_in;
   logic [dfw_pkg::EV_W-1:0] ev_ff;
   logic [VX_W-1:0]         node_ff;
   logic [SLOT_W-1:0]       eslot_ff;
   logic                    last_ff;

   logic                     emit, e_last;
   logic [dfw_pkg::EV_W-1:0] e_ev;
   logic [VX_W-1:0]          e_node;
   logic [SLOT_W-1:0]        e_slot;
   logic                     ovail, follow, has_parent;
   logic [CNT_W-1:0]         n_eff;
   logic [DEG_W-1:0]         pk_dec;

   assign ovail  = !out_valid_ff || rsp_ch.ready;
   assign n_eff  = (vc_ff > CNT_W'(dfw_pkg::MAX_VERTICES)) ?
                   CNT_W'(dfw_pkg::MAX_VERTICES) : vc_ff;
   assign follow = ({1'b0, v_ff} < n_eff) && (col_q == dfw_pkg::COL_WHITE);
   assign has_parent = (u_ff != root_ff) && (depth_ff != '0);
   assign pk_dec = stk_q.k - DEG_W'(1);

   // Sequence one item through the memories
   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      root_in   = root_ff;
      scan_in   = scan_ff;
      clr_in    = clr_ff;
      u_in      = u_ff;
      k_in      = k_ff;
      v_in      = v_ff;
      cmd_ready = 1'b0;
      deg_we = 1'b0; deg_wa = cmd.vertex; deg_re = 1'b0; deg_ra = u_ff;
      nb_we  = 1'b0; nb_wa  = {cmd.vertex, cmd.slot};
      nb_re  = 1'b0; nb_ra  = {u_ff, k_ff[SLOT_W-1:0]};
      col_we = 1'b0; col_wa = u_ff; col_wd = dfw_pkg::COL_WHITE;
      col_re = 1'b0; col_ra = u_ff;
      stk_we = 1'b0; stk_wa = depth_ff[VX_W-1:0]; stk_wd = '{v: u_ff, k: k_ff};
      stk_re = 1'b0; stk_ra = VX_W'(depth_ff - CNT_W'(1));
      emit   = 1'b0;
      e_ev   = dfw_pkg::EV_DONE;
      e_node = '0;
      e_slot = '0;
      e_last = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            col_we = 1'b1;
            col_wa = clr_ff[VX_W-1:0];
            clr_in = clr_ff + CNT_W'(1);
            if (clr_ff == CNT_W'(dfw_pkg::MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               case (cmd.func)
                  dfw_pkg::FUNC_WR_DEG: deg_we = 1'b1;
                  dfw_pkg::FUNC_WR_NB:  nb_we = 1'b1;
                  dfw_pkg::FUNC_START: begin
                     depth_in = '0;
                     root_in  = '0;
                     scan_in  = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = (depth_ff == '0) ? ST_SCAN_RD : ST_POP;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff >= n_eff) begin
               if (ovail) begin
                  emit     = 1'b1;
                  e_ev     = dfw_pkg::EV_DONE;
                  e_last   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               col_re   = 1'b1;
               col_ra   = scan_ff[VX_W-1:0];
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (col_q == dfw_pkg::COL_WHITE) begin
               root_in  = scan_ff[VX_W-1:0];
               u_in     = scan_ff[VX_W-1:0];
               k_in     = '0;
               state_in = ST_U_RD;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP: begin
            stk_re   = 1'b1;
            depth_in = depth_ff - CNT_W'(1);
            state_in = ST_U_LD;
         end
         ST_U_LD: begin
            u_in     = stk_q.v;
            k_in     = stk_q.k;
            state_in = ST_U_RD;
         end
         ST_U_RD: begin
            col_re   = 1'b1;
            deg_re   = 1'b1;
            state_in = ST_U_CHK;
         end
         ST_U_CHK: begin
            if (col_q != dfw_pkg::COL_WHITE) begin
               state_in = ST_BRANCH;
            end else if (ovail) begin
               emit     = 1'b1;
               e_ev     = dfw_pkg::EV_DISCOVER;
               e_node   = u_ff;
               col_we   = 1'b1;
               col_wd   = dfw_pkg::COL_GRAY;
               state_in = ST_BRANCH;
            end
         end
         ST_BRANCH: begin
            if (k_ff < deg_q) begin
               nb_re    = 1'b1;
               state_in = ST_NB;
            end else if (ovail) begin
               col_we   = 1'b1;
               col_wd   = dfw_pkg::COL_BLACK;
               emit     = 1'b1;
               e_ev     = dfw_pkg::EV_FINISH;
               e_node   = u_ff;
               e_last   = !has_parent;
               stk_re   = has_parent;
               state_in = has_parent ? ST_PARENT : ST_IDLE;
            end
         end
         ST_NB: begin
            v_in   = nb_q;
            col_re = 1'b1;
            col_ra = nb_q;
            stk_wd = '{v: u_ff, k: k_ff + DEG_W'(1)};
            if (!depth_ff[CNT_W-1]) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + CNT_W'(1);
            end
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            if (ovail) begin
               emit   = 1'b1;
               e_ev   = dfw_pkg::EV_PRE_EDGE;
               e_node = u_ff;
               e_slot = k_ff[SLOT_W-1:0];
               e_last = follow;
               if (follow) begin
                  stk_wd = '{v: v_ff, k: '0};
                  if (!depth_ff[CNT_W-1]) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + CNT_W'(1);
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            if (ovail) begin
               emit     = 1'b1;
               e_ev     = dfw_pkg::EV_POST_EDGE;
               e_node   = u_ff;
               e_slot   = k_ff[SLOT_W-1:0];
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PARENT: begin
            if (ovail) begin
               emit     = 1'b1;
               e_ev     = dfw_pkg::EV_POST_EDGE;
               e_node   = stk_q.v;
               e_slot   = pk_dec[SLOT_W-1:0];
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         depth_ff     <= '0;
         root_ff      <= '0;
         scan_ff      <= '0;
         clr_ff       <= '0;
         vc_ff        <= CNT_W'(dfw_pkg::MAX_VERTICES);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         root_ff      <= root_in;
         scan_ff      <= scan_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            vc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      k_ff <= k_in;
      v_ff <= v_in;
      if (emit) begin
         ev_ff    <= e_ev;
         node_ff  <= e_node;
         eslot_ff <= e_slot;
         last_ff  <= e_last;
      end
   end

   // Degree table
   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= cmd.degree;
      end
      if (deg_re) begin
         deg_q <= deg_mem[deg_ra];
      end
   end

   // Neighbour table
   always_ff @(posedge clock) begin
      if (nb_we) begin
         nb_mem[nb_wa] <= cmd.neighbor;
      end
      if (nb_re) begin
         nb_q <= nb_mem[nb_ra];
      end
   end

   // Colour table
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_wa] <= col_wd;
      end
      if (col_re) begin
         col_q <= col_mem[col_ra];
      end
   end

   // Frame stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_q <= stk_mem[stk_ra];
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.event_res = ev_ff;
   assign rsp_ch.node      = node_ff;
   assign rsp_ch.edge_slot = eslot_ff;
   assign rsp_ch.last      = last_ff;

endmodule

// ----- sv/graph_depth_first_walker_top.sv -----
// Depth-first walker over a stored adjacency table of up to 1024 vertices with
// up to 16 neighbours each. Load items write a degree or a neighbour slot, a
// start item whitens all vertices and empties the stack, and each step item
// runs one iteration of the explicit-stack walk, giving one to three events
// with last set on the final one. Items are queued (two deep) in front of a
// sequencer that works one item at a time; a step's length depends on its
// path and on the non-white vertices skipped while searching for the next
// root, as the colour, degree, neighbour and stack memories, each with a
// registered read, are read in turn; a result that is not taken holds the
// sequencer until it is. After reset and after every start item the colour
// memory is cleared in a pass over all 1024 vertices, during which queued
// items wait; configuration writes are taken at any time.
module graph_depth_first_walker_top (
   input  logic                      clock,
   input  logic                      reset,
   dfw_req_if.sink                   req_ch,
   dfw_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [dfw_pkg::CNT_W-1:0] csr_wr_data
);

   logic             cmd_valid;
   logic             cmd_ready;
   dfw_pkg::cmd_type cmd;

   // Accept and queue items
   dfw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // Carry out loads, starts and steps
   dfw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ----- sv/dfw_checker.sv -----
module dfw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dfw_pkg::EV_W-1:0]     rsp_event_res,
   input logic [dfw_pkg::VX_W-1:0]     rsp_node,
   input logic [dfw_pkg::SLOT_W-1:0]   rsp_edge_slot,
   input logic                         rsp_last
);

   // A stalled item holds its event and node
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_node))
      else $error("result changed while stalled");

   // Discovery is always followed by another event of the same step
   a_disc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == dfw_pkg::EV_DISCOVER) |-> !rsp_last)
      else $error("discovery marked last");

   // Traversal done stands alone
   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == dfw_pkg::EV_DONE) |->
         rsp_last && (rsp_node == '0) && (rsp_edge_slot == '0))
      else $error("malformed done");

   // Vertex events carry no edge slot
   a_vertex_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == dfw_pkg::EV_DISCOVER) ||
                    (rsp_event_res == dfw_pkg::EV_FINISH)) |-> (rsp_edge_slot == '0))
      else $error("slot on vertex event");

endmodule

bind graph_depth_first_walker_top dfw_checker u_dfw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_event_res (rsp_ch.event_res),
   .rsp_node      (rsp_ch.node),
   .rsp_edge_slot (rsp_ch.edge_slot),
   .rsp_last      (rsp_ch.last)
);
